FILE: hdl/ntcati_pkg.sv
// Shared constants, NTC table and state types for the NTC table interpolator.
package ntcati_pkg;

  localparam int CODE_W  = 12;
  localparam int RS_W    = 20;
  localparam int TEMP_W  = 15;
  localparam int AVG_W   = 12;
  localparam int QUOT_W  = 12;
  localparam int OHM_W   = 17;
  localparam int DT_W    = 11;
  localparam int PROD_W  = 24;

  localparam int MV_FULL   = 3300;
  localparam int CODE_FULL = 4095;
  localparam int MV_LOW    = 10;
  localparam int MV_HIGH   = 3290;
  localparam logic [RS_W-1:0] RS_RESET = RS_W'(10000);

  localparam int TAB_ENTRIES = 21;
  localparam int TAB_IDX_W   = 5;
  localparam logic [TAB_IDX_W-1:0] TAB_LAST_SEG = TAB_IDX_W'(TAB_ENTRIES - 2);

  localparam logic [OHM_W-1:0] TAB_OHMS [TAB_ENTRIES] = '{
    17'd100700, 17'd52700, 17'd28680, 17'd16180, 17'd9420, 17'd6800, 17'd5000,
    17'd3700, 17'd2800, 17'd2550, 17'd2350, 17'd1860, 17'd1150, 17'd750,
    17'd500, 17'd340, 17'd240, 17'd175, 17'd130, 17'd100, 17'd77
  };

  localparam logic signed [TEMP_W-1:0] TAB_CENTI [TAB_ENTRIES] = '{
    -15'sd4000, -15'sd3000, -15'sd2000, -15'sd1000, 15'sd0, 15'sd500, 15'sd1000,
    15'sd1500, 15'sd2000, 15'sd2250, 15'sd2500, 15'sd3000, 15'sd4000, 15'sd5000,
    15'sd6000, 15'sd7000, 15'sd8000, 15'sd9000, 15'sd10000, 15'sd11000, 15'sd12000
  };

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_DATA = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_AVG,
    B_RANGE,
    B_FIRST_MUL,
    B_FIRST_CHK,
    B_WALK_MUL,
    B_WALK_CHK,
    B_INT_LO,
    B_INT_HI,
    B_DIV_START,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

FILE: hdl/ntc_averaged_table_interpolator.sv
// Top level of the NTC thermistor averaging table interpolator.
// Input channel: in_valid/in_stall with adc_code and read_ok. A transfer
// happens when in_valid is high and in_stall low. The front end takes one
// sample per cycle while in_stall is low, scales valid codes to millivolts
// and sums them. Every SAMPLES_PER_RESULT samples it posts a job to a
// two-entry queue. The back end works one job at a time: it picks up the
// job, runs the shared divider for the average, does the range test and
// the cold-end check, walks the table segment by segment, forms the
// interpolation product, divides once more and loads the output. A group
// with no valid reading goes straight to the output load; out-of-range and
// cold-end results skip the steps after their test, and the walk ends at
// the hot clamp if no segment matches.
// Output channel: out_valid/out_stall with status, temperature_centi and
// average_mv from an output register; the back end finishes the next job
// while a result waits. in_stall rises only when the queue is full and a
// group end needs to be posted. Configuration: cfg_valid/cfg_ready with
// cfg_data writes the series resistance; cfg_ready is always high.
// Synchronous reset empties the queue, clears the sums and sample count
// and sets the series resistance to 10000 ohms.
module ntc_averaged_table_interpolator import ntcati_pkg::*; #(
  parameter int SAMPLES_PER_RESULT = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CODE_W-1:0]        adc_code,
  input  logic                     read_ok,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [TEMP_W-1:0] temperature_centi,
  output logic [AVG_W-1:0]         average_mv,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RS_W-1:0]          cfg_data
);

  localparam int SW = $clog2(MV_FULL * SAMPLES_PER_RESULT + 1);
  localparam int CW = $clog2(SAMPLES_PER_RESULT + 1);

  logic [RS_W-1:0]    series_resistance_ohms;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [CW+SW-1:0]   q_in;
  logic [CW+SW-1:0]   q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance_ohms <= RS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      series_resistance_ohms <= cfg_data;
    end
  end

  ntcati_front #(.N(SAMPLES_PER_RESULT), .SW(SW), .CW(CW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .adc_code(adc_code),
    .read_ok (read_ok),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  ntcati_fifo #(.W(CW + SW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ntcati_back #(.SW(SW), .CW(CW)) u_back (
    .clk              (clk),
    .rst              (rst),
    .rs               (series_resistance_ohms),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .temperature_centi(temperature_centi),
    .average_mv       (average_mv)
  );

endmodule

FILE: hdl/ntcati_fifo.sv
// Two-entry job queue between the sample front end and the lookup back end.
module ntcati_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign head  = mem[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/ntcati_front.sv
// Front end: takes samples, scales them to millivolts and builds per-group jobs.
module ntcati_front import ntcati_pkg::*; #(
  parameter int N  = 8,
  parameter int SW = 15,
  parameter int CW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] adc_code,
  input  logic              read_ok,
  input  logic              q_full,
  output logic              q_push,
  output logic [CW+SW-1:0]  q_data
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic              p_vld;
  logic              p_ok;
  logic              p_last;
  logic [PROD_W-1:0] p_prod;
  logic [IW-1:0]     idx;
  logic [SW-1:0]     sum;
  logic [CW-1:0]     cnt;

  logic              accept;
  logic              advance;
  logic [CODE_W-1:0] q0;
  logic [PROD_W-1:0] rem;
  logic [CODE_W-1:0] mv;
  logic [SW-1:0]     sum_next;
  logic [CW-1:0]     cnt_next;

  assign advance  = p_vld && !(p_last && q_full);
  assign in_stall = p_vld && p_last && q_full;
  assign accept   = in_valid && !in_stall;

  // x/4096 underestimates x/4095 by less than one: one correction step
  assign q0  = p_prod[PROD_W-1:CODE_W];
  assign rem = p_prod - ({q0, {CODE_W{1'b0}}} - PROD_W'(q0));
  assign mv  = (rem >= PROD_W'(CODE_FULL)) ? q0 + CODE_W'(1) : q0;

  assign sum_next = sum + (p_ok ? SW'(mv) : SW'(0));
  assign cnt_next = cnt + CW'(p_ok);
  assign q_push   = advance && p_last;
  assign q_data   = {cnt_next, sum_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      p_prod <= PROD_W'(adc_code) * PROD_W'(MV_FULL);
      p_ok   <= read_ok;
      p_last <= (idx == IW'(N - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      idx   <= '0;
      sum   <= '0;
      cnt   <= '0;
    end else begin
      if (accept) begin
        p_vld <= 1'b1;
        idx   <= (idx == IW'(N - 1)) ? '0 : idx + IW'(1);
      end else if (advance) begin
        p_vld <= 1'b0;
      end
      if (advance) begin
        if (p_last) begin
          sum <= '0;
          cnt <= '0;
        end else begin
          sum <= sum_next;
          cnt <= cnt_next;
        end
      end
    end
  end

endmodule

FILE: hdl/ntcati_div.sv
// Restoring divider: one quotient bit per cycle, shared by the back end.
module ntcati_div import ntcati_pkg::*; #(
  parameter int W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int DSW = W + QUOT_W - 1;
  localparam int KW  = $clog2(QUOT_W);

  logic           run;
  logic [KW-1:0]  k;
  logic [W-1:0]   rem;
  logic [DSW-1:0] dsh;
  logic           ge;

  assign ge = (DSW'(rem) >= dsh);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= DSW'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (run) begin
      if (ge) begin
        rem <= rem - W'(dsh);
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      k    <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        k   <= KW'(QUOT_W - 1);
      end else if (run) begin
        if (k == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - KW'(1);
        end
      end
    end
  end

endmodule

FILE: hdl/ntcati_back.sv
// Back end: average, range test, resistance table walk and interpolation.
module ntcati_back import ntcati_pkg::*; #(
  parameter int SW = 15,
  parameter int CW = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [RS_W-1:0]          rs,
  input  logic                     q_empty,
  input  logic [CW+SW-1:0]         q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [TEMP_W-1:0] temperature_centi,
  output logic [AVG_W-1:0]         average_mv
);

  localparam int PW = RS_W + SW;
  localparam int NW = PW + 13;
  localparam int H  = PW / 2;

  back_state_t state, state_next;

  logic [SW-1:0]        s;
  logic [CW-1:0]        n;
  logic [SW-1:0]        d;
  logic [PW-1:0]        p;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        hi;
  logic [PW-1:0]        den;
  logic [PW-1:0]        diff;
  logic [NW-1:0]        num;
  logic [TAB_IDX_W-1:0] idx;
  logic [TAB_IDX_W-1:0] idx_nx;
  status_t              res_status;
  logic signed [TEMP_W-1:0] res_temp;
  logic [AVG_W-1:0]     res_avg;

  logic [SW-1:0]        h_s;
  logic [CW-1:0]        h_n;
  logic                 out_load;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic [NW-1:0]        div_den;
  logic                 div_done;
  logic [QUOT_W-1:0]    div_quot;
  logic                 out_range;
  logic                 found;
  logic signed [TEMP_W-1:0] dt_full;
  logic [DT_W-1:0]      dt;

  assign {h_n, h_s} = q_head;
  assign idx_nx     = idx + TAB_IDX_W'(1);
  assign out_range  = (PW'(s) <= PW'(n) * PW'(MV_LOW)) ||
                      (PW'(s) >= PW'(n) * PW'(MV_HIGH));
  assign found      = (p >= prod);
  assign dt_full    = TAB_CENTI[idx_nx] - TAB_CENTI[idx];
  assign dt         = dt_full[DT_W-1:0];
  assign out_load   = (state == B_DONE) && (!out_valid || !out_stall);

  ntcati_div #(.W(NW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (!q_empty) state_next = (h_n == '0) ? B_DONE : B_AVG;
      B_AVG:       if (div_done) state_next = B_RANGE;
      B_RANGE:     state_next = out_range ? B_DONE : B_FIRST_MUL;
      B_FIRST_MUL: state_next = B_FIRST_CHK;
      B_FIRST_CHK: state_next = found ? B_DONE : B_WALK_MUL;
      B_WALK_MUL:  state_next = B_WALK_CHK;
      B_WALK_CHK: begin
        if (found) begin
          state_next = B_INT_LO;
        end else if (idx == TAB_LAST_SEG) begin
          state_next = B_DONE;
        end else begin
          state_next = B_WALK_MUL;
        end
      end
      B_INT_LO:    state_next = B_INT_HI;
      B_INT_HI:    state_next = B_DIV_START;
      B_DIV_START: state_next = B_DIV;
      B_DIV:       if (div_done) state_next = B_DONE;
      B_DONE:      if (out_load) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = NW'(h_s);
    div_den   = NW'(h_n);
    case (state)
      B_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty && (h_n != '0);
      end
      B_DIV_START: begin
        div_start = 1'b1;
        div_num   = {num[NW-2:0], 1'b0} + NW'(den);
        div_den   = {NW'(den)} << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        s          <= h_s;
        n          <= h_n;
        res_status <= STATUS_NO_DATA;
        res_temp   <= '0;
        res_avg    <= '0;
      end
      B_AVG: begin
        if (div_done) res_avg <= div_quot;
      end
      B_RANGE: begin
        res_status <= out_range ? STATUS_RANGE : STATUS_OK;
        d          <= SW'(SW'(n) * SW'(MV_FULL) - s);
        p          <= PW'(rs) * PW'(s);
      end
      B_FIRST_MUL: begin
        prod <= PW'(TAB_OHMS[0]) * PW'(d);
        idx  <= '0;
      end
      B_FIRST_CHK: begin
        hi <= prod;
        if (found) res_temp <= TAB_CENTI[0];
      end
      B_WALK_MUL: begin
        prod <= PW'(TAB_OHMS[idx_nx]) * PW'(d);
      end
      B_WALK_CHK: begin
        if (found) begin
          den  <= hi - prod;
          diff <= hi - p;
        end else begin
          hi <= prod;
          // past the last segment: hot clamp
          if (idx == TAB_LAST_SEG) begin
            res_temp <= TAB_CENTI[TAB_ENTRIES - 1];
          end else begin
            idx <= idx_nx;
          end
        end
      end
      B_INT_LO: begin
        num <= NW'(diff[H-1:0]) * NW'(dt);
      end
      B_INT_HI: begin
        num <= num + ((NW'(diff[PW-1:H]) * NW'(dt)) << H);
      end
      B_DIV: begin
        if (div_done) res_temp <= TAB_CENTI[idx] + TEMP_W'(div_quot);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status            <= res_status;
      temperature_centi <= res_temp;
      average_mv        <= res_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/tb_ntc_averaged_table_interpolator.sv
// Self-checking testbench for the NTC averaging table interpolator.
module tb_ntc_averaged_table_interpolator;
  import ntcati_pkg::*;

  localparam int GROUP = 8;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    status_t                  st;
    logic signed [TEMP_W-1:0] temp;
    logic [AVG_W-1:0]         avg;
  } reading_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              ok;
    logic              chk;   // compare against the typed-in result
    reading_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CODE_W-1:0] adc_code = '0;
  logic read_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [AVG_W-1:0] average_mv;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RS_W-1:0] cfg_data = '0;

  ntc_averaged_table_interpolator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .adc_code(adc_code), .read_ok(read_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .temperature_centi(temperature_centi), .average_mv(average_mv),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [RS_W-1:0] pullup_ohms;
  int unsigned grp_count, mv_sum, ok_count;
  reading_t expected_readings[$];
  reading_t pinned_readings[$];
  logic pin_next[$];

  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  bit directed = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("error @%0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  function automatic logic signed [TEMP_W-1:0] ohms_to_centi(
      input longint unsigned num, input longint unsigned den);
    longint unsigned hi, lo, dt, prod, off;
    if (num >= longint'(TAB_OHMS[0]) * den) return TAB_CENTI[0];
    if (num <= longint'(TAB_OHMS[TAB_ENTRIES-1]) * den) return TAB_CENTI[TAB_ENTRIES-1];
    for (int i = 0; i < TAB_ENTRIES - 1; i++) begin
      hi = longint'(TAB_OHMS[i]) * den;
      lo = longint'(TAB_OHMS[i+1]) * den;
      if (num <= hi && num >= lo) begin
        dt = longint'(TAB_CENTI[i+1] - TAB_CENTI[i]);
        prod = (hi - num) * dt;
        off = (2 * prod + (hi - lo)) / (2 * (hi - lo));
        return TAB_CENTI[i] + TEMP_W'(off);
      end
    end
    return TAB_CENTI[TAB_ENTRIES-1];
  endfunction

  // Fold one accepted sample into the group; queue a reading at group end.
  task automatic take_sample(input logic [CODE_W-1:0] code, input logic ok);
    reading_t r;
    longint unsigned s, n;
    if (ok) begin
      mv_sum += (code * MV_FULL) / CODE_FULL;
      ok_count++;
    end
    grp_count++;
    if (grp_count < GROUP) return;
    r.st = STATUS_OK; r.temp = '0; r.avg = '0;
    if (ok_count == 0) r.st = STATUS_NO_DATA;
    else begin
      s = mv_sum; n = ok_count;
      r.avg = AVG_W'(s / n);
      if (s <= MV_LOW * n || s >= MV_HIGH * n) r.st = STATUS_RANGE;
      else r.temp = ohms_to_centi(longint'(pullup_ohms) * s, MV_FULL * n - s);
    end
    expected_readings.push_back(r);
    grp_count = 0; mv_sum = 0; ok_count = 0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ntc_averaged_table_interpolator: mismatch");
      $finish;
    end
  end

  // count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    reading_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_readings.size() == 0) report("unexpected result", status, -1);
        else begin
          w = expected_readings.pop_front();
          if (pin_next.size() != 0 && pin_next.pop_front()) begin
            if (pinned_readings.size() != 0) w = pinned_readings.pop_front();
          end
          if (status !== w.st) report("status", status, w.st);
          if (temperature_centi !== w.temp) report("temperature_centi", temperature_centi, w.temp);
          if (average_mv !== w.avg) report("average_mv", average_mv, w.avg);
        end
      end
      if (hold_off > 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(input logic [CODE_W-1:0] code, input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; adc_code <= code; read_ok <= ok;
    do @(posedge clk); while (in_stall);
    take_sample(code, ok);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_pullup(input logic [RS_W-1:0] ohms);
    drain();
    cfg_valid <= 1'b1; cfg_data <= ohms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pullup_ohms = ohms;
  endtask

  // one random group, mostly plausible voltages with a few edge codes
  task automatic random_group();
    int kind;
    logic [CODE_W-1:0] base;
    kind = $urandom_range(99);
    base = $urandom_range(4095);
    for (int i = 0; i < GROUP; i++) begin
      if (kind < 60) send(CODE_W'($urandom_range(400, 3700)), $urandom_range(9) != 0);
      else if (kind < 75) send(CODE_W'(base + $urandom_range(8)), 1'b1);
      else if (kind < 85) send(CODE_W'($urandom_range(4095)), $urandom_range(3) == 0);
      else if (kind < 92) send(CODE_W'($urandom_range(20)), $urandom_range(1));
      else send(CODE_W'($urandom_range(4075, 4095)), $urandom_range(1));
    end
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t row(input int code, input bit ok, input bit chk,
                                    input status_t st, input int temp, input int avg);
    stim_row_t r;
    r.code = CODE_W'(code); r.ok = ok; r.chk = chk;
    r.want.st = st; r.want.temp = TEMP_W'(temp); r.want.avg = AVG_W'(avg);
    return r;
  endfunction

  initial begin
    int phase_idle[4] = '{0, 52, 0, 36};
    int phase_stall[4] = '{0, 0, 52, 36};
    logic [RS_W-1:0] pullups[5] = '{RS_W'(100), RS_W'(1000000), RS_W'(20'hFFFFF),
                                    RS_W'(0), RS_W'(4700)};
    pullup_ohms = RS_RESET;
    grp_count = 0; mv_sum = 0; ok_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all invalid -> no data
    for (int i = 0; i < GROUP; i++) rows.push_back(row(4095, 0, i == GROUP-1,
                                                        STATUS_NO_DATA, 0, 0));
    // all zero codes -> out of range, average 0
    for (int i = 0; i < GROUP; i++) rows.push_back(row(0, 1, i == GROUP-1,
                                                        STATUS_RANGE, 0, 0));
    // full scale -> out of range, average 3300
    for (int i = 0; i < GROUP; i++) rows.push_back(row(4095, 1, i == GROUP-1,
                                                        STATUS_RANGE, 0, 3300));
    foreach (rows[k]) begin
      send(rows[k].code, rows[k].ok);
      if (rows[k].chk) begin
        pin_next.push_back(1'b1);
        pinned_readings.push_back(rows[k].want);
      end else if (grp_count == 0) pin_next.push_back(1'b0);
    end
    // midscale and near-threshold groups checked by prediction
    for (int i = 0; i < GROUP; i++) send(CODE_W'(2048), 1'b1);
    for (int i = 0; i < GROUP; i++) send(CODE_W'(13 + i), i[0]);
    drain();
    pin_next.delete();

    for (int p = 0; p < 5; p++) begin
      set_pullup(pullups[p]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = phase_idle[ph];
        stall_pct = phase_stall[ph];
        for (int g = 0; g < 9; g++) random_group();
      end
    end

    // hold the receiver off while the sender keeps going, then pause
    set_pullup(RS_RESET);
    send_idle_pct = 0; stall_pct = 0;
    hold_off <= 600;
    for (int g = 0; g < 6; g++) random_group();
    drain();
    stall_pct = 20;
    for (int g = 0; g < 4; g++) random_group();
    drain();

    $display("covered %0d results over five pull-up settings plus reset value,", results_seen);
    $display("with idle, stall and back-pressure phases");
    if (errors == 0) $display("ntc_averaged_table_interpolator: match");
    else $display("ntc_averaged_table_interpolator: mismatch");
    $finish;
  end
endmodule

FILE: ntc_averaged_table_interpolator.f
hdl/ntcati_pkg.sv
hdl/ntcati_fifo.sv
hdl/ntcati_front.sv
hdl/ntcati_div.sv
hdl/ntcati_back.sv
hdl/ntc_averaged_table_interpolator.sv
tb/tb_ntc_averaged_table_interpolator.sv
